FILE: hw/rtl/htpd_pkg.sv
// shared constants and register index codes for the homogeneous transform block
package htpd_pkg;

  localparam int VALUE_FRAC = 16;
  localparam int LANE_W     = 16;
  localparam int NUM_IN     = 4;
  localparam int NUM_OUT    = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMN_X,
    REG_COLUMN_Y,
    REG_COLUMN_Z,
    REG_COLUMN_W,
    REG_DIVIDE_ENABLE,
    REG_NEAR_ZERO_LIMIT
  } cfg_reg_e;

endpackage

FILE: hw/rtl/htpd_dot.sv
// two-stage dot product of the input vector with one packed coefficient column
module htpd_dot #(
  parameter int VALUE_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                                clk_i,
  input  logic                                en_a_i,
  input  logic                                en_b_i,
  input  logic [3:0][VALUE_WIDTH-1:0]         vec_i,
  input  logic [htpd_pkg::CFG_DATA_W-1:0]     col_i,
  output logic [VALUE_WIDTH+5:0]              t_o
);
  import htpd_pkg::*;

  localparam int PW = VALUE_WIDTH + COEF_WIDTH;
  localparam int SW = PW + 2;
  localparam int CF = COEF_WIDTH - 4;
  localparam int TW = VALUE_WIDTH + 6;

  logic signed [PW-1:0] prod_d [NUM_IN];
  logic signed [PW-1:0] prod_q [NUM_IN];
  logic signed [SW-1:0] sum;
  logic        [TW-1:0] t_q;

  always_comb begin
    for (int i = 0; i < NUM_IN; i++) begin
      prod_d[i] = $signed({{COEF_WIDTH{vec_i[i][VALUE_WIDTH-1]}}, vec_i[i]}) *
                  $signed({{VALUE_WIDTH{col_i[LANE_W*i+COEF_WIDTH-1]}},
                           col_i[LANE_W*i +: COEF_WIDTH]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      for (int i = 0; i < NUM_IN; i++) prod_q[i] <= prod_d[i];
    end
  end

  // floor shift of the exact sum drops the coefficient fraction
  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_IN; i++) sum = sum + SW'(prod_q[i]);
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) t_q <= sum[SW-1:CF];
  end

  assign t_o = t_q;

endmodule

FILE: hw/rtl/htpd_div_cell.sv
// one restoring-division step for the three components, with its own valid stage
module htpd_div_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               valid_i,
  output logic                                               ready_o,
  output logic                                               valid_o,
  input  logic                                               ready_i,
  input  logic                                               div_i,
  output logic                                               div_o,
  input  logic                                               wneg_i,
  output logic                                               wneg_o,
  input  logic [VALUE_WIDTH+5:0]                             dvsr_i,
  output logic [VALUE_WIDTH+5:0]                             dvsr_o,
  input  logic [2:0][VALUE_WIDTH+5+htpd_pkg::VALUE_FRAC:0]   num_i,
  output logic [2:0][VALUE_WIDTH+5+htpd_pkg::VALUE_FRAC:0]   num_o,
  input  logic [2:0][VALUE_WIDTH+5:0]                        rem_i,
  output logic [2:0][VALUE_WIDTH+5:0]                        rem_o,
  input  logic [2:0][VALUE_WIDTH:0]                          quo_i,
  output logic [2:0][VALUE_WIDTH:0]                          quo_o,
  input  logic [2:0]                                         ovf_i,
  output logic [2:0]                                         ovf_o,
  input  logic [2:0][VALUE_WIDTH+5:0]                        t_i,
  output logic [2:0][VALUE_WIDTH+5:0]                        t_o
);
  import htpd_pkg::*;

  localparam int TW = VALUE_WIDTH + 6;
  localparam int NW = TW + VALUE_FRAC;
  localparam int QW = VALUE_WIDTH + 1;

  logic                        valid_q;
  logic                        div_q, wneg_q;
  logic [TW-1:0]               dvsr_q;
  logic [2:0][NW-1:0]          num_d, num_q;
  logic [2:0][TW-1:0]          rem_d, rem_q;
  logic [2:0][QW-1:0]          quo_d, quo_q;
  logic [2:0]                  ovf_d, ovf_q;
  logic [2:0][TW-1:0]          t_q;
  logic [TW:0]                 r2;
  logic                        ge;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    r2 = '0;
    ge = 1'b0;
    for (int l = 0; l < NUM_OUT; l++) begin
      r2       = {rem_i[l], num_i[l][NW-1]};
      ge       = r2 >= {1'b0, dvsr_i};
      rem_d[l] = ge ? TW'(r2 - {1'b0, dvsr_i}) : r2[TW-1:0];
      num_d[l] = {num_i[l][NW-2:0], 1'b0};
      quo_d[l] = {quo_i[l][QW-2:0], ge};
      // a set bit shifted out of the quotient means it is out of range
      ovf_d[l] = ovf_i[l] | quo_i[l][QW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      div_q  <= div_i;
      wneg_q <= wneg_i;
      dvsr_q <= dvsr_i;
      num_q  <= num_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      ovf_q  <= ovf_d;
      t_q    <= t_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign wneg_o  = wneg_q;
  assign dvsr_o  = dvsr_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign ovf_o   = ovf_q;
  assign t_o     = t_q;

endmodule

FILE: hw/rtl/homogeneous_transform_persp_divide_top.sv
// top level: 4x4 transform, divide by transformed w through a row of division cells
//
// Input channel: in_valid_i with in_x_i..in_w_i, stalled by in_stall_o. An item
// enters when in_valid_i is high and in_stall_o is low. Output channel:
// out_valid_o with out_x_o, out_y_o, out_z_o, divided_o, saturated_o, stalled
// by out_stall_i. Configuration: cfg_we_i writes cfg_data_i into register
// cfg_index_i (columns x, y, z, w, divide enable, near-zero limit); the user
// must write only while the block is empty, as the block does not enforce it.
// Throughput: one item per cycle while the receiver does not stall. An item
// passes the product and column-sum stages, the division cell row with one
// cell for each of the VALUE_WIDTH + 22 quotient bits, and the output register.
// Each stage moves on when its successor has room, so a stall of the receiver
// fills the bubbles first and then holds every item in place. Reset empties
// all stages and loads the identity matrix, divide enabled and a near-zero
// limit of 66.
module homogeneous_transform_persp_divide_top #(
  parameter int VALUE_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [htpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [htpd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [VALUE_WIDTH-1:0]              in_x_i,
  input  logic [VALUE_WIDTH-1:0]              in_y_i,
  input  logic [VALUE_WIDTH-1:0]              in_z_i,
  input  logic [VALUE_WIDTH-1:0]              in_w_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [VALUE_WIDTH-1:0]              out_x_o,
  output logic [VALUE_WIDTH-1:0]              out_y_o,
  output logic [VALUE_WIDTH-1:0]              out_z_o,
  output logic                                divided_o,
  output logic                                saturated_o
);
  import htpd_pkg::*;

  localparam int TW     = VALUE_WIDTH + 6;
  localparam int NW     = TW + VALUE_FRAC;
  localparam int QW     = VALUE_WIDTH + 1;
  localparam int NSTEPS = NW;
  localparam int CF     = COEF_WIDTH - 4;
  localparam logic [CFG_DATA_W-1:0] ONE = CFG_DATA_W'(1) << CF;
  localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // configuration registers
  logic [3:0][CFG_DATA_W-1:0] col_q;
  logic                       div_en_q;
  logic [LANE_W-1:0]          limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q[0] <= ONE;
      col_q[1] <= ONE << LANE_W;
      col_q[2] <= ONE << (2 * LANE_W);
      col_q[3] <= ONE << (3 * LANE_W);
      div_en_q <= 1'b1;
      limit_q  <= LANE_W'(66);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_COLUMN_X:        col_q[0] <= cfg_data_i;
        REG_COLUMN_Y:        col_q[1] <= cfg_data_i;
        REG_COLUMN_Z:        col_q[2] <= cfg_data_i;
        REG_COLUMN_W:        col_q[3] <= cfg_data_i;
        REG_DIVIDE_ENABLE:   div_en_q <= cfg_data_i[0];
        REG_NEAR_ZERO_LIMIT: limit_q  <= cfg_data_i[LANE_W-1:0];
        default: ;
      endcase
    end
  end

  // front stages: products, then column sums
  logic va_q, vb_q, en_a, en_b;
  logic [NSTEPS:0] cv, crdy;
  logic [3:0][VALUE_WIDTH-1:0] vec;
  logic [3:0][TW-1:0]          tcol;

  assign en_b       = !vb_q || crdy[0];
  assign en_a       = !va_q || en_b;
  assign in_stall_o = !en_a;
  assign vec        = {in_w_i, in_z_i, in_y_i, in_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_col
    htpd_dot #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .COEF_WIDTH (COEF_WIDTH)
    ) u_dot (
      .clk_i (clk_i),
      .en_a_i(en_a),
      .en_b_i(en_b),
      .vec_i (vec),
      .col_i (col_q[c]),
      .t_o   (tcol[c])
    );
  end

  // division cell row
  logic [NSTEPS:0]                   cdiv, cwneg;
  logic [NSTEPS:0][TW-1:0]           cdvsr;
  logic [NSTEPS:0][2:0][NW-1:0]      cnum;
  logic [NSTEPS:0][2:0][TW-1:0]      crem;
  logic [NSTEPS:0][2:0][QW-1:0]      cquo;
  logic [NSTEPS:0][2:0]              covf;
  logic [NSTEPS:0][2:0][TW-1:0]      ct;
  logic [TW-1:0]                     wmag;

  always_comb begin
    wmag     = tcol[3][TW-1] ? TW'(-tcol[3]) : tcol[3];
    cv[0]    = vb_q;
    cwneg[0] = tcol[3][TW-1];
    cdvsr[0] = wmag;
    cdiv[0]  = div_en_q && (wmag > TW'(limit_q));
    for (int l = 0; l < NUM_OUT; l++) begin
      ct[0][l]   = tcol[l];
      cnum[0][l] = {(tcol[l][TW-1] ? TW'(-tcol[l]) : tcol[l]), {VALUE_FRAC{1'b0}}};
      crem[0][l] = '0;
      cquo[0][l] = '0;
      covf[0][l] = 1'b0;
    end
  end

  for (genvar s = 0; s < NSTEPS; s++) begin : g_cell
    htpd_div_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cv[s]),
      .ready_o(crdy[s]),
      .valid_o(cv[s+1]),
      .ready_i(crdy[s+1]),
      .div_i  (cdiv[s]),
      .div_o  (cdiv[s+1]),
      .wneg_i (cwneg[s]),
      .wneg_o (cwneg[s+1]),
      .dvsr_i (cdvsr[s]),
      .dvsr_o (cdvsr[s+1]),
      .num_i  (cnum[s]),
      .num_o  (cnum[s+1]),
      .rem_i  (crem[s]),
      .rem_o  (crem[s+1]),
      .quo_i  (cquo[s]),
      .quo_o  (cquo[s+1]),
      .ovf_i  (covf[s]),
      .ovf_o  (covf[s+1]),
      .t_i    (ct[s]),
      .t_o    (ct[s+1])
    );
  end

  // result selection and saturation
  logic                              out_en, out_valid_q;
  logic [2:0][VALUE_WIDTH-1:0]       res_d, res_q;
  logic                              sat_d, sat_q, divd_q;
  logic [QW-1:0]                     q;
  logic [TW-1:0]                     t;
  logic                              neg;

  assign out_en        = !out_valid_q || !out_stall_i;
  assign crdy[NSTEPS]  = out_en;

  always_comb begin
    sat_d = 1'b0;
    q     = '0;
    t     = '0;
    neg   = 1'b0;
    for (int l = 0; l < NUM_OUT; l++) begin
      q   = cquo[NSTEPS][l];
      t   = ct[NSTEPS][l];
      neg = t[TW-1] ^ cwneg[NSTEPS];
      if (cdiv[NSTEPS]) begin
        if (!neg) begin
          if (covf[NSTEPS][l] || q[QW-1] || q[QW-2]) begin
            res_d[l] = VMAX;
            sat_d    = 1'b1;
          end else begin
            res_d[l] = q[VALUE_WIDTH-1:0];
          end
        end else if (covf[NSTEPS][l] || q[QW-1] || (q[QW-2] && (|q[QW-3:0]))) begin
          res_d[l] = VMIN;
          sat_d    = 1'b1;
        end else begin
          res_d[l] = VALUE_WIDTH'(-q[VALUE_WIDTH-1:0]);
        end
      end else if ((&t[TW-1:VALUE_WIDTH-1]) || !(|t[TW-1:VALUE_WIDTH-1])) begin
        res_d[l] = t[VALUE_WIDTH-1:0];
      end else begin
        res_d[l] = t[TW-1] ? VMIN : VMAX;
        sat_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= cv[NSTEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      res_q  <= res_d;
      sat_q  <= sat_d;
      divd_q <= cdiv[NSTEPS];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign divided_o   = divd_q;
  assign saturated_o = sat_q;

  // an accepted item lands in the product stage
  a_accept_to_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> va_q)
    else $error("accepted item lost before product stage");

  // the last cell holds its item while the output register is full and stalled
  a_last_cell_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[NSTEPS] && !crdy[NSTEPS] |=> cv[NSTEPS])
    else $error("last division cell dropped a stalled item");

  // the front stage never takes an item while the sum stage cannot move
  a_front_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q && vb_q && !crdy[0] |-> in_stall_o)
    else $error("input accepted while front stages are blocked");

endmodule
